@@ sv/srb_pkg.sv @@
// Shared types and constants of the system-integration register block.
`default_nettype none
package srb_pkg;

  localparam int SRB_STORE_WORDS = 1024;

  localparam logic [10:0] UART_LO        = 11'h700;
  localparam logic [11:0] UART_HI        = 12'h722;
  localparam logic [10:0] ID_OFFSET      = 11'h002;
  localparam logic [7:0]  ID_VALUE       = 8'h31;
  localparam logic [10:0] DMA_STAT_A     = 11'h78A;
  localparam logic [10:0] DMA_STAT_B     = 11'h7AA;
  localparam logic [7:0]  DMA_W1C_MASK   = 8'h7C;
  localparam logic [7:0]  DMA_ANY_BIT    = 8'h80;
  localparam logic [10:0] CS_BASE_OFFSET = 11'h044;
  localparam logic [2:0]  MAX_SIZE       = 3'd4;

  localparam logic REG_DUART_PRESENT = 1'b0;
  localparam logic REG_BOOT_HOOK     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd_issue;
    logic modify;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic more;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ sv/srb_ctrl.sv @@
// Sequencer of the register block: clearing pass, byte loop and result hand-off.
`default_nettype none
module srb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire srb_pkg::status_t status,
  output srb_pkg::cmd_t        cmd
);
  import srb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = status.more ? ST_MODIFY : ST_FINISH;
      end
      ST_MODIFY: begin
        state_next = ST_READ;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_READ: begin
        cmd.rd_issue = status.more;
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/srb_datapath.sv @@
// Datapath of the register block: word store, byte merge, read assembly, result register.
`default_nettype none
module srb_datapath #(
  parameter int STORE_WORDS = srb_pkg::SRB_STORE_WORDS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire srb_pkg::cmd_t   cmd,
  output srb_pkg::status_t     status,
  input  wire logic            duart_present,
  input  wire logic            boot_hook_enable,
  input  wire logic            in_is_write,
  input  wire logic [10:0]     in_offset,
  input  wire logic [2:0]      in_size,
  input  wire logic [31:0]     in_wdata,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [31:0]          m_tdata,  // read_data
  output logic [1:0]           m_tuser   // to_uart, overlay_retired
);
  import srb_pkg::*;

  localparam int BA_W  = $clog2(2 * STORE_WORDS);
  localparam int WA_W  = BA_W - 1;
  localparam int SUM_W = BA_W + 1;
  localparam logic [SUM_W-1:0] STORE_BYTES = SUM_W'(2 * STORE_WORDS);
  localparam logic [WA_W-1:0]  LAST_WORD   = WA_W'(STORE_WORDS - 1);

  logic [15:0]     mem [STORE_WORDS];
  logic [15:0]     mem_rdata;
  logic [15:0]     mem_wdata;
  logic [WA_W-1:0] mem_addr;
  logic            mem_we;

  logic [WA_W-1:0] clr_cnt;
  logic            is_write;
  logic [10:0]     offset;
  logic [2:0]      size;
  logic [31:0]     wdata;
  logic [31:0]     rd;
  logic [2:0]      k;
  logic            diverted;
  logic            overlay_done;

  logic [2:0]       size_clamped;
  logic [11:0]      in_end;
  logic             in_diverted;
  logic [SUM_W-1:0] addr_sum;
  logic [BA_W-1:0]  baddr;
  logic             is_id;
  logic             is_dma;
  logic [7:0]       rbyte;
  logic [1:0]       widx;
  logic [7:0]       wbyte;
  logic [7:0]       dma_st;
  logic             retire;

  assign size_clamped = (in_size > MAX_SIZE) ? MAX_SIZE : in_size;
  assign in_end       = {1'b0, in_offset} + {9'd0, size_clamped};
  assign in_diverted  = duart_present && (in_offset >= UART_LO) &&
                        ({1'b0, in_offset} < UART_HI) && (in_end <= UART_HI);

  always_comb begin
    addr_sum = SUM_W'(offset) + SUM_W'(k);
    if (addr_sum >= STORE_BYTES) addr_sum = addr_sum - STORE_BYTES;
  end

  assign baddr  = addr_sum[BA_W-1:0];
  assign is_id  = (baddr == BA_W'(ID_OFFSET));
  assign is_dma = (baddr == BA_W'(DMA_STAT_A)) || (baddr == BA_W'(DMA_STAT_B));
  assign rbyte  = is_id ? ID_VALUE : (baddr[0] ? mem_rdata[7:0] : mem_rdata[15:8]);
  assign widx   = 2'(size - 3'd1 - k);
  assign wbyte  = wdata[widx*8 +: 8];

  always_comb begin
    dma_st = mem_rdata[15:8] & ~wbyte & DMA_W1C_MASK;
    if (dma_st != 8'd0) dma_st = dma_st | DMA_ANY_BIT;
    if (is_dma) begin
      mem_wdata = {dma_st, mem_rdata[7:0]};
    end else if (baddr[0]) begin
      mem_wdata = {mem_rdata[15:8], wbyte};
    end else begin
      mem_wdata = {wbyte, mem_rdata[7:0]};
    end
    if (cmd.clear_step) mem_wdata = 16'd0;
  end

  assign mem_addr = cmd.clear_step ? clr_cnt : baddr[BA_W-1:1];
  assign mem_we   = cmd.clear_step || (cmd.modify && is_write && !is_id);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd_issue) mem_rdata <= mem[mem_addr];
  end

  assign retire = is_write && !diverted && (offset == CS_BASE_OFFSET) &&
                  !overlay_done && boot_hook_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      overlay_done <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + WA_W'(1);
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        if (retire) overlay_done <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write <= in_is_write;
      offset   <= in_offset;
      size     <= size_clamped;
      wdata    <= in_wdata;
      diverted <= in_diverted;
      rd       <= '0;
      k        <= '0;
    end
    if (cmd.modify) begin
      if (!is_write) rd <= {rd[23:0], rbyte};
      k <= k + 3'd1;
    end
    if (cmd.finish) begin
      m_tdata <= is_write ? 32'd0 : rd;
      m_tuser <= {retire, diverted};
    end
  end

  assign status.clear_last = (clr_cnt == LAST_WORD);
  assign status.more       = (k < size) && !diverted;
  assign status.out_free   = !m_tvalid || m_tready;

endmodule
`default_nettype wire

@@ sv/sim_register_block.sv @@
// Top level of the system-integration register block: configuration and sequencer/datapath.
// An access goes from ST_IDLE through ST_READ and ST_MODIFY per byte (size 0..4, none if
// diverted), then a last ST_READ and ST_FINISH, which loads the result register. It is taken
// only in ST_IDLE; each byte is a read and, for a write, a write of the single-port word
// store, and a result still waiting holds back the next one. Reset: synchronous; then a
// clearing pass zeroes the store, taking no input transfer (configuration writes still are).
`default_nettype none
module sim_register_block #(
  parameter int STORE_WORDS = srb_pkg::SRB_STORE_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // byte_offset[10:0], access_size[13:11], write_data[45:14]
  input  wire logic [0:0]  s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // read_data
  output logic [1:0]       m_tuser,  // to_uart, overlay_retired
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic        cfg_wdata
);
  import srb_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    duart_present;
  logic    boot_hook_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      duart_present    <= 1'b1;
      boot_hook_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DUART_PRESENT: duart_present    <= cfg_wdata;
        REG_BOOT_HOOK:     boot_hook_enable <= cfg_wdata;
        default:           duart_present    <= duart_present;
      endcase
    end
  end

  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srb_datapath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .duart_present    (duart_present),
    .boot_hook_enable (boot_hook_enable),
    .in_is_write      (s_tuser[0]),
    .in_offset        (s_tdata[10:0]),
    .in_size          (s_tdata[13:11]),
    .in_wdata         (s_tdata[45:14]),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser)
  );

endmodule
`default_nettype wire
